[rtl/gn2d_pkg.sv]
// Package for the 2D gradient noise unit: hash constants, parameter defaults
// and the elaboration-time gradient magnitude function.
// No dependencies.
package gn2d_pkg;

  // Default parameter values
  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned ANGLE_BITS_DEF = 10;
  localparam int unsigned GRAD_BITS_DEF  = 16;

  // Hash multipliers
  localparam logic [31:0] HASH_MUL_X = 32'd3284157443;
  localparam logic [31:0] HASH_MUL_Y = 32'd1911520717;
  localparam logic [31:0] HASH_MUL_H = 32'd2048419325;

  // Quarter wave constants in Q30
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned PIH_Q30 = 64'd1686629713;

  // Rotate a 32-bit word by 16
  function automatic logic [31:0] rotl16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // Gradient magnitude for quarter-wave step idx, evaluated at elaboration only
  function automatic logic [23:0] grad_mag_of(input int unsigned idx,
                                              input int unsigned abits,
                                              input int unsigned gbits);
    longint unsigned u;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned t;
    longint unsigned m;
    longint unsigned g;
    longint unsigned lim;
    u  = 64'(idx) << (32 - abits);
    z  = (u * PIH_Q30) >> 30;
    z2 = (z * z) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((z2 * t) >> 30) / 156;
    t  = ONE_Q30 - ((z2 * t) >> 30) / 110;
    t  = ONE_Q30 - ((z2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((z2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((z2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((z2 * t) >> 30) / 6;
    m  = (z * t) >> 30;
    g  = (m + (64'd1 << (30 - gbits))) >> (31 - gbits);
    lim = (64'd1 << (gbits - 1)) - 64'd1;
    if (g > lim) g = lim;
    return 24'(g);
  endfunction

endpackage

[rtl/gn2d_front.sv]
// Front end of the 2D gradient noise unit: takes a sample word and splits it
// into lattice cell and fractional offset. Depends on gn2d_pkg.
module gn2d_front #(
  parameter int unsigned FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [23:0]          in_x_coord,
  input  logic signed [23:0]          in_y_coord,
  output logic                        push,
  input  logic                        q_full,
  output logic [31:0]                 cell_x,
  output logic [31:0]                 cell_y,
  output logic [FRAC_BITS-1:0]        frac_x,
  output logic [FRAC_BITS-1:0]        frac_y
);
  import gn2d_pkg::*;

  logic                 valid_r;
  logic [31:0]          cx_r;
  logic [31:0]          cy_r;
  logic [FRAC_BITS-1:0] fx_r;
  logic [FRAC_BITS-1:0] fy_r;
  logic                 take;

  // Hold the word while the queue is full
  assign busy = valid_r & q_full;
  assign take = start & ~busy;
  assign push = valid_r & ~q_full;

  // Control: word valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (push) begin
      valid_r <= 1'b0;
    end
  end

  // Split into floor cell and fraction
  always_ff @(posedge clk) begin
    if (take) begin
      cx_r <= 32'(in_x_coord >>> FRAC_BITS);
      cy_r <= 32'(in_y_coord >>> FRAC_BITS);
      fx_r <= in_x_coord[FRAC_BITS-1:0];
      fy_r <= in_y_coord[FRAC_BITS-1:0];
    end
  end

  assign cell_x = cx_r;
  assign cell_y = cy_r;
  assign frac_x = fx_r;
  assign frac_y = fy_r;
endmodule

[rtl/gn2d_queue.sv]
// Two-entry queue between front and back of the gradient noise unit.
// Depends on gn2d_pkg.
module gn2d_queue #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  output logic             pop,
  output logic [WIDTH-1:0] rd_data
);
  import gn2d_pkg::*;

  logic [WIDTH-1:0] mem_r [2];
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;
  logic             wp_r;
  logic             rp_r;

  // Drain one word per cycle whenever one is present
  assign pop     = (cnt_r != 2'd0);
  assign full    = (cnt_r == 2'd2);
  assign rd_data = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  // Write storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end
endmodule

[rtl/gn2d_back.sv]
// Back end of the gradient noise unit: hash, gradient lookup, dot products,
// fade blend and height mapping in a fixed pipeline. Depends on gn2d_pkg.
module gn2d_back #(
  parameter int unsigned FRAC_BITS  = gn2d_pkg::FRAC_BITS_DEF,
  parameter int unsigned ANGLE_BITS = gn2d_pkg::ANGLE_BITS_DEF,
  parameter int unsigned GRAD_BITS  = gn2d_pkg::GRAD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [31:0]          cell_x,
  input  logic [31:0]          cell_y,
  input  logic [FRAC_BITS-1:0] frac_x,
  input  logic [FRAC_BITS-1:0] frac_y,
  output logic                 out_valid,
  output logic [7:0]           out_height
);
  import gn2d_pkg::*;

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned G   = GRAD_BITS;
  localparam int unsigned MW  = G - 1;
  localparam int unsigned QN  = 1 << (ANGLE_BITS - 2);
  localparam int unsigned RW  = ANGLE_BITS - 2;
  localparam int unsigned TW  = ANGLE_BITS - 1;
  localparam int unsigned DW  = F + G + 2;
  localparam int unsigned NST = 12;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // Gradient magnitude table, QN+1 entries
  logic [MW-1:0] mag_tbl [QN+1];
  for (genvar i = 0; i <= QN; i++) begin : g_tbl
    assign mag_tbl[i] = MW'(grad_mag_of(i, ANGLE_BITS, G));
  end

  logic [NST-1:0] v_r;

  // Stage 1: x hashes, fade squares
  logic [31:0]  hx0_r, hx1_r, cy1_r;
  logic [F-1:0] fx1_r, fy1_r;
  logic [15:0]  tx_r, ty_r;
  logic [31:0]  tx2_r, ty2_r;
  logic [15:0]  tx_nxt, ty_nxt;
  // Stage 2
  logic [31:0]  s2hx0_r, s2hx1_r;
  logic [31:0]  hy_r [4];
  logic [F-1:0] fx2_r, fy2_r;
  logic [23:0]  px_r, py_r;
  logic [31:0]  cpx_r, cpy_r;
  // Stage 3
  logic [31:0]  h_r [4];
  logic [F-1:0] fx3_r, fy3_r;
  logic [16:0]  wx3_r, wy3_r;
  // Stage 4
  logic signed [G-1:0] gx_r [4];
  logic signed [G-1:0] gy_r [4];
  logic [F-1:0] fx4_r, fy4_r;
  logic [16:0]  wx4_r, wy4_r;
  // Stage 5
  logic signed [F+G:0] pa_r [4];
  logic signed [F+G:0] pb_r [4];
  logic [16:0]  wx5_r, wy5_r;
  // Stage 6
  logic signed [DW-1:0] dot_r [4];
  logic [16:0]  wx6_r, wy6_r;
  // Stage 7
  logic signed [DW+18:0] bp0_r, bp1_r;
  logic signed [DW-1:0]  a0_r, a1_r;
  logic [16:0]  wy7_r;
  // Stage 8
  logic signed [DW-1:0] ix0_r, ix1_r;
  logic [16:0]  wy8_r;
  // Stage 9
  logic signed [DW+18:0] bp2_r;
  logic signed [DW-1:0]  ix0b_r;
  // Stage 10
  logic signed [DW:0] sum_r;
  // Stage 11
  logic [DW+7:0] hm_r;
  logic          pos_r;
  // Stage 12
  logic [7:0]    ht_r;

  logic [DW+7:0] hsh;

  assign tx_nxt = 16'(16'(frac_x) << (16 - F));
  assign ty_nxt = 16'(16'(frac_y) << (16 - F));

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // Hash and fade stages
  always_ff @(posedge clk) begin
    // stage 1
    hx0_r <= cell_x * HASH_MUL_X;
    hx1_r <= (cell_x + 32'd1) * HASH_MUL_X;
    cy1_r <= cell_y;
    fx1_r <= frac_x;
    fy1_r <= frac_y;
    tx_r  <= tx_nxt;
    ty_r  <= ty_nxt;
    tx2_r <= 32'(tx_nxt) * 32'(tx_nxt);
    ty2_r <= 32'(ty_nxt) * 32'(ty_nxt);
    // stage 2: corner order 00, 10, 01, 11
    s2hx0_r  <= hx0_r;
    s2hx1_r  <= hx1_r;
    hy_r[0]  <= (cy1_r ^ rotl16(hx0_r)) * HASH_MUL_Y;
    hy_r[1]  <= (cy1_r ^ rotl16(hx1_r)) * HASH_MUL_Y;
    hy_r[2]  <= ((cy1_r + 32'd1) ^ rotl16(hx0_r)) * HASH_MUL_Y;
    hy_r[3]  <= ((cy1_r + 32'd1) ^ rotl16(hx1_r)) * HASH_MUL_Y;
    fx2_r    <= fx1_r;
    fy2_r    <= fy1_r;
    px_r  <= 24'((40'(tx2_r) * 40'd6 + (40'd10 << 32) - 40'd15 * (40'(tx_r) << 16)) >> 16);
    py_r  <= 24'((40'(ty2_r) * 40'd6 + (40'd10 << 32) - 40'd15 * (40'(ty_r) << 16)) >> 16);
    cpx_r <= 32'((48'(tx2_r) * 48'(tx_r)) >> 16);
    cpy_r <= 32'((48'(ty2_r) * 48'(ty_r)) >> 16);
    // stage 3
    h_r[0] <= (s2hx0_r ^ rotl16(hy_r[0])) * HASH_MUL_H;
    h_r[1] <= (s2hx1_r ^ rotl16(hy_r[1])) * HASH_MUL_H;
    h_r[2] <= (s2hx0_r ^ rotl16(hy_r[2])) * HASH_MUL_H;
    h_r[3] <= (s2hx1_r ^ rotl16(hy_r[3])) * HASH_MUL_H;
    fx3_r  <= fx2_r;
    fy3_r  <= fy2_r;
    wx3_r  <= 17'((56'(cpx_r) * 56'(px_r)) >> 32);
    wy3_r  <= 17'((56'(cpy_r) * 56'(py_r)) >> 32);
  end

  // Gradient lookup: quadrant picks sign and axis swap
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      logic [ANGLE_BITS-1:0] idx;
      logic [RW-1:0]         r;
      logic signed [G-1:0]   sm, cm;
      idx = h_r[k][31 -: ANGLE_BITS];
      r   = idx[RW-1:0];
      sm  = $signed({1'b0, mag_tbl[TW'(r)]});
      cm  = $signed({1'b0, mag_tbl[TW'(QN) - TW'(r)]});
      case (idx[ANGLE_BITS-1 -: 2])
        QUAD_0: begin gx_r[k] <= cm;  gy_r[k] <= sm;  end
        QUAD_1: begin gx_r[k] <= -sm; gy_r[k] <= cm;  end
        QUAD_2: begin gx_r[k] <= -cm; gy_r[k] <= -sm; end
        default: begin gx_r[k] <= sm; gy_r[k] <= -cm; end
      endcase
    end
    fx4_r <= fx3_r;
    fy4_r <= fy3_r;
    wx4_r <= wx3_r;
    wy4_r <= wy3_r;
  end

  // Dot products: offsets toward far corners carry the minus-one bit
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      logic signed [F:0] dx, dy;
      dx = $signed({k[0], fx4_r});
      dy = $signed({k[1], fy4_r});
      pa_r[k] <= dx * gx_r[k];
      pb_r[k] <= dy * gy_r[k];
    end
    wx5_r <= wx4_r;
    wy5_r <= wy4_r;
    for (int k = 0; k < 4; k++) begin
      dot_r[k] <= DW'(pa_r[k]) + DW'(pb_r[k]);
    end
    wx6_r <= wx5_r;
    wy6_r <= wy5_r;
  end

  // Blend along x, then along y
  always_ff @(posedge clk) begin
    bp0_r <= (DW+19)'((DW+1)'(dot_r[1]) - (DW+1)'(dot_r[0])) * $signed({2'b0, wx6_r});
    bp1_r <= (DW+19)'((DW+1)'(dot_r[3]) - (DW+1)'(dot_r[2])) * $signed({2'b0, wx6_r});
    a0_r  <= dot_r[0];
    a1_r  <= dot_r[2];
    wy7_r <= wy6_r;
    ix0_r <= a0_r + DW'(bp0_r >>> 16);
    ix1_r <= a1_r + DW'(bp1_r >>> 16);
    wy8_r <= wy7_r;
    bp2_r <= (DW+19)'((DW+1)'(ix1_r) - (DW+1)'(ix0_r)) * $signed({2'b0, wy8_r});
    ix0b_r <= ix0_r;
    sum_r <= (DW+1)'(ix0b_r + DW'(bp2_r >>> 16)) + ((DW+1)'(1) <<< (F + G - 1));
  end

  // Map to height and saturate
  assign hsh = hm_r >> (F + G);
  always_ff @(posedge clk) begin
    pos_r <= (sum_r > 0);
    hm_r  <= (DW+8)'(sum_r[DW-1:0]) * (DW+8)'(255);
    if (!pos_r) begin
      ht_r <= 8'd0;
    end else if (hsh > (DW+8)'(255)) begin
      ht_r <= 8'd255;
    end else begin
      ht_r <= hsh[7:0];
    end
  end

  assign out_valid  = v_r[NST-1];
  assign out_height = ht_r;
endmodule

[rtl/gradient_noise_2d_unit.sv]
// 2D gradient noise unit: one sample point in, one 8-bit height out.
// out_valid rises once the sample accepted with start has passed the front
// register, a queue entry and the back-end stages; throughput one word per cycle,
// set by the fully pipelined back end (hash, lookup, dot, blend, map).
// The result strobe cannot be stalled, so busy stays low in steady use.
// Synchronous active-low reset clears all valid flags; no table clearing.
// Depends on gn2d_pkg, gn2d_front, gn2d_queue, gn2d_back.
module gradient_noise_2d_unit #(
  parameter int unsigned FRAC_BITS  = gn2d_pkg::FRAC_BITS_DEF,
  parameter int unsigned ANGLE_BITS = gn2d_pkg::ANGLE_BITS_DEF,
  parameter int unsigned GRAD_BITS  = gn2d_pkg::GRAD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] in_x_coord,
  input  logic signed [23:0] in_y_coord,
  output logic               out_valid,
  output logic [7:0]         out_height
);
  import gn2d_pkg::*;

  localparam int unsigned QW = 64 + 2 * FRAC_BITS;

  logic                 push, q_full, pop;
  logic [31:0]          cx, cy;
  logic [FRAC_BITS-1:0] fx, fy;
  logic [QW-1:0]        q_rd;

  // Front: accept and split
  gn2d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n, .start, .busy, .in_x_coord, .in_y_coord,
    .push, .q_full, .cell_x(cx), .cell_y(cy), .frac_x(fx), .frac_y(fy)
  );

  // Queue between front and back
  gn2d_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst_n, .push, .wr_data({cx, cy, fx, fy}),
    .full(q_full), .pop, .rd_data(q_rd)
  );

  // Back: noise pipeline
  gn2d_back #(
    .FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS), .GRAD_BITS(GRAD_BITS)
  ) u_back (
    .clk, .rst_n, .in_valid(pop),
    .cell_x(q_rd[QW-1 -: 32]), .cell_y(q_rd[QW-33 -: 32]),
    .frac_x(q_rd[2*FRAC_BITS-1 -: FRAC_BITS]), .frac_y(q_rd[FRAC_BITS-1:0]),
    .out_valid, .out_height
  );
endmodule
